// ----- sv/hkm_pkg.sv -----
// ----------------------------------------------------------------------------
// hkm_pkg
// Types and constants shared by the heap merge controller and datapath.
// ----------------------------------------------------------------------------
package hkm_pkg;

   localparam int ValueW     = 32;
   localparam int SourceW    = 4;
   localparam int OccupancyW = 5;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_REPLACE = 2'd1,
      OP_RETIRE  = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_TOP,
      RD_PARENT,
      RD_CHILDREN
   } rd_sel_type;

   typedef struct packed {
      logic signed [ValueW-1:0] value;
      logic [SourceW-1:0]       source;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_TOP,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       load_begin;
      logic       set_status;
      status_type status_code;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       take_top;
      logic       move_up;
      logic       move_down;
      logic       write_cur;
      logic       res_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   at_root;
      logic   up_move;
      logic   dn_move;
      logic   out_free;
   } stat_type;

endpackage

// ----- sv/hkm_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkm_ctrl
// Sequencer for load, replace and retire: decode, sift up or sift down one
// heap level per read and compare state pair, then hand the result word to the output register.
// ----------------------------------------------------------------------------
module hkm_ctrl
   import hkm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_OK;
      cmd.rd_sel      = RD_TOP;
      req_stall       = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.op == OP_LOAD) begin
               if (stat.full) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_FULL;
                  state_in        = S_FINISH;
               end else begin
                  cmd.load_begin = 1'b1;
                  state_in       = S_UP_RD;
               end
            end else if (stat.op == OP_REPLACE || stat.op == OP_RETIRE) begin
               if (stat.empty) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_EMPTY;
                  state_in        = S_FINISH;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_TOP;
                  state_in   = S_TOP;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_TOP: begin
            cmd.take_top = 1'b1;
            state_in     = S_DN_RD;
         end
         S_UP_RD: begin
            if (stat.at_root) begin
               cmd.write_cur = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_move) begin
               cmd.move_up = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.write_cur = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_DN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CHILDREN;
            state_in   = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.dn_move) begin
               cmd.move_down = 1'b1;
               state_in      = S_DN_RD;
            end else begin
               cmd.write_cur = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/hkm_datapath.sv -----
// ----------------------------------------------------------------------------
// hkm_datapath
// Heap memory with one write and two registered read ports, the moving entry,
// position and count registers, the comparators and the result register.
// ----------------------------------------------------------------------------
module hkm_datapath
   import hkm_pkg::*;
#(
   parameter int MAX_SOURCES = 16
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_opcode,
   input  logic signed [ValueW-1:0]     req_value,
   input  logic [SourceW-1:0]           req_source,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_emitted,
   output logic signed [ValueW-1:0]     rsp_out_value,
   output logic [SourceW-1:0]           rsp_out_source,
   output logic [OccupancyW-1:0]        rsp_occupancy,
   output logic [1:0]                   rsp_status,
   input  cmd_type                      cmd,
   output stat_type                     stat
);

   localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CW = $clog2(MAX_SOURCES + 1);
   localparam int XW = AW + 2;

   entry_type heap_mem [MAX_SOURCES];

   entry_type  rd0_ff, rd1_ff;
   entry_type  cur_ff, cur_in;
   op_type     op_ff, op_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;

   logic       res_emitted_ff, res_emitted_in;
   entry_type  res_entry_ff, res_entry_in;
   status_type res_status_ff, res_status_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_emitted_ff;
   entry_type  out_entry_ff;
   logic [CW-1:0] out_count_ff;
   status_type out_status_ff;

   logic [AW-1:0] pos_m1, parent_idx, last_idx;
   logic [XW-1:0] left_idx, right_idx, count_x;
   logic          left_ok, right_ok, take_left, take_right;
   logic signed [ValueW-1:0] best_value;
   entry_type     child_entry;
   logic [AW-1:0] child_pos;
   logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
   entry_type     wr_data;
   logic          wr_en;
   logic [CW-1:0] count_m1;

   assign pos_m1     = pos_ff - AW'(1);
   assign parent_idx = pos_m1 >> 1;
   assign count_m1   = count_ff - CW'(1);
   assign last_idx   = count_m1[AW-1:0];
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = {1'b0, pos_ff, 1'b0} + XW'(2);
   assign count_x    = XW'(count_ff);

   assign left_ok    = left_idx < count_x;
   assign right_ok   = right_idx < count_x;
   assign take_left  = left_ok && (rd0_ff.value < cur_ff.value);
   assign best_value = take_left ? rd0_ff.value : cur_ff.value;
   assign take_right = right_ok && (rd1_ff.value < best_value);
   assign child_entry = take_right ? rd1_ff : rd0_ff;
   assign child_pos   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PARENT: begin
            rd_addr0 = parent_idx;
            rd_addr1 = parent_idx;
         end
         RD_CHILDREN: begin
            rd_addr0 = left_idx[AW-1:0];
            rd_addr1 = right_idx[AW-1:0];
         end
         default: begin
            rd_addr0 = '0;
            rd_addr1 = last_idx;
         end
      endcase
   end

   always_comb begin
      wr_en   = cmd.move_up || cmd.move_down || cmd.write_cur;
      wr_addr = pos_ff;
      priority if (cmd.move_up) begin
         wr_data = rd0_ff;
      end else if (cmd.move_down) begin
         wr_data = child_entry;
      end else begin
         wr_data = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd0_ff <= heap_mem[rd_addr0];
         rd1_ff <= heap_mem[rd_addr1];
      end
   end

   always_comb begin
      op_in          = op_ff;
      cur_in         = cur_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      res_emitted_in = res_emitted_ff;
      res_entry_in   = res_entry_ff;
      res_status_in  = res_status_ff;
      out_valid_in   = out_valid_ff && rsp_stall;

      if (cmd.latch) begin
         op_in          = op_type'(req_opcode);
         cur_in.value   = req_value;
         cur_in.source  = req_source;
         res_emitted_in = 1'b0;
         res_entry_in   = '0;
         res_status_in  = ST_OK;
      end
      if (cmd.set_status) begin
         res_status_in = cmd.status_code;
      end
      if (cmd.load_begin) begin
         pos_in   = count_ff[AW-1:0];
         count_in = count_ff + CW'(1);
      end
      if (cmd.take_top) begin
         res_emitted_in = 1'b1;
         res_entry_in   = rd0_ff;
         pos_in         = '0;
         if (op_ff == OP_RETIRE) begin
            cur_in   = rd1_ff;
            count_in = count_m1;
         end
      end
      if (cmd.move_up) begin
         pos_in = parent_idx;
      end
      if (cmd.move_down) begin
         pos_in = child_pos;
      end
      if (cmd.res_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      cur_ff         <= cur_in;
      pos_ff         <= pos_in;
      res_emitted_ff <= res_emitted_in;
      res_entry_ff   <= res_entry_in;
      res_status_ff  <= res_status_in;
      if (cmd.res_load) begin
         out_emitted_ff <= res_emitted_ff;
         out_entry_ff   <= res_entry_ff;
         out_count_ff   <= count_ff;
         out_status_ff  <= res_status_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_emitted    = out_emitted_ff;
   assign rsp_out_value  = out_entry_ff.value;
   assign rsp_out_source = out_entry_ff.source;
   assign rsp_occupancy  = OccupancyW'(out_count_ff);
   assign rsp_status     = out_status_ff;

   assign stat.op       = op_ff;
   assign stat.empty    = count_ff == '0;
   assign stat.full     = count_ff == CW'(MAX_SOURCES);
   assign stat.at_root  = pos_ff == '0;
   assign stat.up_move  = cur_ff.value < rd0_ff.value;
   assign stat.dn_move  = take_left || take_right;
   assign stat.out_free = !out_valid_ff || !rsp_stall;

endmodule

// ----- sv/heap_kway_merge_unit.sv -----
// ----------------------------------------------------------------------------
// heap_kway_merge_unit
// K-way merge with a binary min-heap of (value, source) entries.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Word
//  req      in         req_valid/req_stall  opcode, value, source
//  rsp      out        rsp_valid/rsp_stall  emitted, out_value, out_source,
//                                           occupancy, status
//
// One word is in flight at a time. From acceptance to the result offer, a load
// climbs at most the heap depth, four levels for sixteen entries, and a replace
// or retire descends at most as far, while a refused or unused opcode goes from
// decode straight to the result. The next word is accepted only from the idle
// state. Reset clears the heap count and the output valid flag; the heap
// memory itself is not cleared. A stalled result stays in the output register
// while the next word is accepted and worked on, and that word's result waits
// until the output register is free.
// ----------------------------------------------------------------------------
module heap_kway_merge_unit
   import hkm_pkg::*;
#(
   parameter int MAX_SOURCES = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic signed [ValueW-1:0]  req_value,
   input  logic [SourceW-1:0]        req_source,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_emitted,
   output logic signed [ValueW-1:0]  rsp_out_value,
   output logic [SourceW-1:0]        rsp_out_source,
   output logic [OccupancyW-1:0]     rsp_occupancy,
   output logic [1:0]                rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   hkm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   hkm_datapath #(
      .MAX_SOURCES (MAX_SOURCES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .req_source     (req_source),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_emitted    (rsp_emitted),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_source (rsp_out_source),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

// ----- test/tb_heap_kway_merge_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heap_kway_merge_unit
// Self-checking bench for the heap k-way merge unit. An internal heap tracker
// predicts every result word from the accepted request words. The stimulus
// opens with fill, overflow and underflow cases at the value extremes. It
// then runs merge batches of sorted and unsorted sources, mixed with stray
// opcodes, with random stalls on both channels in all but the last regime.
// ----------------------------------------------------------------------------
module tb_heap_kway_merge_unit
   import hkm_pkg::*;
;

   localparam int MaxSources = 16;
   localparam logic signed [ValueW-1:0] DirectedHeads [MaxSources] = '{
      32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd5, 32'sd5, 32'sd5, 32'sd1,
      32'sh7fff_ffff, 32'sh8000_0000, 32'sd100, -32'sd100, 32'sd7, 32'sd3, 32'sd5, 32'sd0
   };

   typedef struct packed {
      logic                     emitted;
      logic signed [ValueW-1:0] value;
      logic [SourceW-1:0]       source;
      logic [OccupancyW-1:0]    occupancy;
      status_type               status;
   } merge_word_type;

   class merge_scoreboard_type;
      entry_type      heap_mem [MaxSources];
      int             heap_size = 0;
      merge_word_type pending_outputs [$];
      int unsigned    mismatches = 0;
      int unsigned    words_checked = 0;
      int unsigned    emits_seen = 0;
      int unsigned    full_flags = 0;
      int unsigned    empty_flags = 0;

      function logic signed [ValueW-1:0] top_value();
         return heap_mem[0].value;
      endfunction

      function logic [SourceW-1:0] top_source();
         return heap_mem[0].source;
      endfunction

      function bit lower(entry_type a, entry_type b);
         return $signed(a.value) < $signed(b.value);
      endfunction

      function void swap_slots(int a, int b);
         entry_type t;
         t = heap_mem[a];
         heap_mem[a] = heap_mem[b];
         heap_mem[b] = t;
      endfunction

      function void climb(int pos);
         int up;
         while (pos != 0) begin
            up = (pos - 1) / 2;
            if (!lower(heap_mem[pos], heap_mem[up])) break;
            swap_slots(pos, up);
            pos = up;
         end
      endfunction

      function void descend(int pos);
         int best;
         while (1) begin
            best = pos;
            if (2 * pos + 1 < heap_size && lower(heap_mem[2 * pos + 1], heap_mem[best]))
               best = 2 * pos + 1;
            if (2 * pos + 2 < heap_size && lower(heap_mem[2 * pos + 2], heap_mem[best]))
               best = 2 * pos + 2;
            if (best == pos) break;
            swap_slots(pos, best);
            pos = best;
         end
      endfunction

      function status_type note_request(op_type op, logic signed [ValueW-1:0] value,
                                        logic [SourceW-1:0] source);
         merge_word_type w;
         entry_type e;
         w = '0;
         e.value = value;
         e.source = source;
         case (op)
            OP_LOAD: begin
               if (heap_size >= MaxSources) begin
                  w.status = ST_FULL;
               end else begin
                  heap_mem[heap_size] = e;
                  heap_size++;
                  climb(heap_size - 1);
               end
            end
            OP_REPLACE, OP_RETIRE: begin
               if (heap_size == 0) begin
                  w.status = ST_EMPTY;
               end else begin
                  w.emitted = 1'b1;
                  w.value = heap_mem[0].value;
                  w.source = heap_mem[0].source;
                  if (op == OP_REPLACE) begin
                     heap_mem[0] = e;
                  end else begin
                     heap_mem[0] = heap_mem[heap_size - 1];
                     heap_size--;
                  end
                  descend(0);
               end
            end
            default: ;
         endcase
         w.occupancy = OccupancyW'(heap_size);
         pending_outputs = {pending_outputs, w};
         return w.status;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(merge_word_type got);
         merge_word_type want;
         if (pending_outputs.size() == 0) begin
            report("result word arrived with no request outstanding");
            return;
         end
         want = pending_outputs.pop_front();
         words_checked++;
         if (want.emitted) emits_seen++;
         if (want.status == ST_FULL) full_flags++;
         if (want.status == ST_EMPTY) empty_flags++;
         if (got.emitted !== want.emitted)
            report($sformatf("emitted expected %0d, got %0d", want.emitted, got.emitted));
         if (got.value !== want.value)
            report($sformatf("out_value expected %0d, got %0d", want.value, got.value));
         if (got.source !== want.source)
            report($sformatf("out_source expected %0d, got %0d", want.source, got.source));
         if (got.occupancy !== want.occupancy)
            report($sformatf("occupancy expected %0d, got %0d", want.occupancy,
                             got.occupancy));
         if (got.status !== want.status)
            report($sformatf("status expected %0d, got %0d", want.status, got.status));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_opcode;
   logic signed [ValueW-1:0] req_value;
   logic [SourceW-1:0]       req_source;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_emitted;
   logic signed [ValueW-1:0] rsp_out_value;
   logic [SourceW-1:0]       rsp_out_source;
   logic [OccupancyW-1:0]    rsp_occupancy;
   logic [1:0]               rsp_status;

   merge_scoreboard_type sb = new();
   int                   tx_idle_pct = 0;
   int                   rx_idle_pct = 0;
   int                   useful_words = 0;

   heap_kway_merge_unit #(.MAX_SOURCES(MaxSources)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_value(req_value), .req_source(req_source),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_emitted(rsp_emitted), .rsp_out_value(rsp_out_value),
      .rsp_out_source(rsp_out_source), .rsp_occupancy(rsp_occupancy),
      .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      merge_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.emitted = rsp_emitted;
         got.value = rsp_out_value;
         got.source = rsp_out_source;
         got.occupancy = rsp_occupancy;
         got.status = status_type'(rsp_status);
         sb.check_result(got);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task send_word(op_type op, logic signed [ValueW-1:0] value, logic [SourceW-1:0] source);
      status_type st;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value <= value;
      req_source <= source;
      do @(posedge clock); while (req_stall);
      st = sb.note_request(op, value, source);
      if (op != OP_NONE && st == ST_OK) useful_words++;
      @(negedge clock);
   endtask

   task drain_pending();
      req_valid <= 1'b0;
      while (sb.pending_outputs.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function logic signed [ValueW-1:0] pick_value(int mode);
      case (mode)
         0:       return ValueW'($urandom_range(0, 8)) - 32'sd4;
         1:       return ValueW'($urandom_range(0, 2000)) - 32'sd1000;
         default: return $urandom;
      endcase
   endfunction

   function longint pick_step(int mode);
      case (mode)
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(0, 50);
         default: return $urandom_range(0, 32'h0fff_ffff);
      endcase
   endfunction

   task run_merge_batch();
      int                       fan_in;
      int                       mode;
      int                       roll;
      bit                       ordered;
      longint                   nxt;
      logic [SourceW-1:0]       src;
      fan_in = $urandom_range(1, MaxSources);
      mode = $urandom_range(0, 2);
      ordered = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < fan_in && sb.heap_size < MaxSources; i++)
         send_word(OP_LOAD, pick_value(mode), SourceW'($urandom_range(0, 15)));
      if ($urandom_range(0, 7) == 0)
         send_word(OP_LOAD, pick_value(mode), SourceW'($urandom_range(0, 15)));
      while (sb.heap_size != 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_word(OP_NONE, $urandom, SourceW'($urandom_range(0, 15)));
         end else if (roll < 12 && sb.heap_size < MaxSources) begin
            send_word(OP_LOAD, pick_value(mode), SourceW'($urandom_range(0, 15)));
         end else if (roll < 72) begin
            if (ordered) begin
               nxt = longint'(sb.top_value()) + pick_step(mode);
               if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
               src = ($urandom_range(0, 9) != 0) ? sb.top_source()
                                                  : SourceW'($urandom_range(0, 15));
               send_word(OP_REPLACE, nxt[ValueW-1:0], src);
            end else begin
               send_word(OP_REPLACE, pick_value(mode), SourceW'($urandom_range(0, 15)));
            end
         end else begin
            send_word(OP_RETIRE, pick_value(mode), SourceW'($urandom_range(0, 15)));
         end
      end
      if ($urandom_range(0, 3) == 0)
         send_word(op_type'($urandom_range(1, 2)), $urandom, SourceW'($urandom_range(0, 15)));
   endtask

   task run_regime(int tx_pct, int rx_pct, int target_total);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      while (useful_words < target_total) run_merge_batch();
      drain_pending();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_NONE;
      req_value = '0;
      req_source = '0;
      rsp_stall = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_idle_pct = 11;
      rx_idle_pct = 76;
      send_word(OP_RETIRE, '0, '0);
      send_word(OP_REPLACE, 32'sh7fff_ffff, 4'd15);
      send_word(OP_NONE, 32'sh8000_0000, 4'd15);
      for (int i = 0; i < MaxSources; i++)
         send_word(OP_LOAD, DirectedHeads[i], SourceW'(i));
      send_word(OP_LOAD, -32'sd5, 4'd9);
      send_word(OP_NONE, -32'sd1, 4'd0);
      send_word(OP_REPLACE, 32'sh8000_0000, 4'd3);
      send_word(OP_REPLACE, 32'sh7fff_ffff, 4'd12);
      send_word(OP_RETIRE, '0, '0);
      send_word(OP_RETIRE, '0, '0);

      run_regime(11, 76, 217);
      run_regime(76, 11, 434);
      run_regime(0, 0, 650);

      repeat (40) @(posedge clock);
      if (sb.pending_outputs.size() != 0)
         sb.report($sformatf("%0d expected words never arrived", sb.pending_outputs.size()));
      $display("Run covered %0d result words: %0d merged outputs, %0d loads into a full heap,",
               sb.words_checked, sb.emits_seen, sb.full_flags);
      $display("and %0d emits from an empty heap, under three stall patterns.", sb.empty_flags);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Run timed out with %0d words outstanding.", sb.pending_outputs.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- heap_kway_merge_unit.f -----
sv/hkm_pkg.sv
sv/hkm_ctrl.sv
sv/hkm_datapath.sv
sv/heap_kway_merge_unit.sv
test/tb_heap_kway_merge_unit.sv
